// ===== design/kflerp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kflerp_pkg;
   localparam int MaxKeys   = 64;
   localparam int SlotW     = $clog2(MaxKeys);
   localparam int CountW    = 7;
   localparam int TimeW     = 32;
   localparam int ValW      = 32;
   localparam int Lanes     = 3;
   localparam int FracW     = 17;
   localparam int QuotBits  = 17;

   localparam logic CmdLoad   = 1'b0;
   localparam logic CmdSample = 1'b1;

   // Work handed from the control sequencer to the blend lanes.
   typedef struct packed {
      logic             start;
      logic [FracW-1:0] frac;
   } lane_ctl_type;
endpackage
`default_nettype wire

// ===== design/kflerp_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One blend lane: out = a + floor((d * f + 2^15) / 2^16), d = b - a.
module kflerp_lane (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire kflerp_pkg::lane_ctl_type          ctl,
   input  wire signed [kflerp_pkg::ValW-1:0]      val_a,
   input  wire signed [kflerp_pkg::ValW-1:0]      val_b,
   output logic signed [kflerp_pkg::ValW-1:0]     result,
   output logic                                   done
);
   logic signed [kflerp_pkg::ValW:0]     diff_ff, diff_in;
   logic signed [kflerp_pkg::ValW-1:0]   base_ff;
   logic        [kflerp_pkg::FracW-1:0]  frac_ff;
   logic signed [50:0]                   prod_ff, prod_in;
   logic        [1:0]                    stage_ff;
   logic signed [50:0]                   rnd;

   assign diff_in = {val_b[kflerp_pkg::ValW-1], val_b} - {val_a[kflerp_pkg::ValW-1], val_a};
   assign prod_in = 51'(diff_ff * $signed({1'b0, frac_ff}));
   assign rnd     = prod_ff + 51'sd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= {stage_ff[0], ctl.start};
      end
      if (ctl.start) begin
         diff_ff <= diff_in;
         base_ff <= val_a;
         frac_ff <= ctl.frac;
      end
      if (stage_ff[0]) begin
         prod_ff <= prod_in;
      end
   end

   // Arithmetic shift is a floor division by 2^16.
   assign result = base_ff + 32'(rnd >>> 16);
   assign done   = stage_ff[1];
endmodule
`default_nettype wire

// ===== design/kflerp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider: quotient = floor(num * 2^16 / den), one bit per cycle,
// saturated to 65536. num < den is not required; large quotients saturate.
module kflerp_div (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire [kflerp_pkg::TimeW-1:0]         num,
   input  wire [kflerp_pkg::TimeW-1:0]         den,
   output logic [kflerp_pkg::FracW-1:0]        quot,
   output logic                                done
);
   logic [kflerp_pkg::TimeW:0]   rem_ff, rem_in;
   logic [kflerp_pkg::TimeW-1:0] den_ff;
   logic [kflerp_pkg::TimeW-1:0] hi_ff;
   logic [5:0]                   cnt_ff;
   logic                         busy_ff, done_ff, sat_ff;
   logic [kflerp_pkg::QuotBits-1:0] q_ff;
   logic [kflerp_pkg::TimeW:0]   trial;

   // num*2^16 shifted in one bit at a time; integer part first (32 bits), then 16 zeros.
   assign trial  = {rem_ff[kflerp_pkg::TimeW-1:0], (cnt_ff < 6'd32) ? hi_ff[31] : 1'b0};
   assign rem_in = (trial >= {1'b0, den_ff}) ? trial - {1'b0, den_ff} : trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == 6'd47);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            hi_ff   <= num;
            den_ff  <= den;
            q_ff    <= '0;
            sat_ff  <= 1'b0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            hi_ff  <= {hi_ff[30:0], 1'b0};
            // A set bit leaving the top of the quotient means it exceeds the limit.
            if (q_ff[kflerp_pkg::QuotBits-1]) begin
               sat_ff <= 1'b1;
            end
            q_ff   <= {q_ff[kflerp_pkg::QuotBits-2:0], trial >= {1'b0, den_ff}};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign quot = (sat_ff || q_ff > 17'd65536) ? 17'd65536 : q_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

// ===== design/keyframe_vec3_lerp_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Keyframe track sampler. A load item (command 0) writes one keyframe into
// the track and gives no result; a sample item (command 1) gives one blended
// (x, y, z) result. A sample scans the stored key times one per cycle, reads
// the segment's two keys from the key memory, runs a bit-serial divider for
// the blend factor and then three parallel multiply lanes; a single key or a
// zero-length segment skips the divider and lanes and gives the start key's value.
// Loads are taken one per cycle while idle. A new item is taken while a
// result waits; a sample that finishes while the output still holds an
// untaken result waits in its last step. The memory holds no reset value:
// every key in use must be loaded before sampling. The user must write
// key_count on the csr channel only while idle; the block does not enforce it.
module keyframe_vec3_lerp_sampler (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [0:0]   req_tuser,   // command
   input  wire  [167:0] req_tdata,   // key_slot[5:0], key_time, key_x, key_y, key_z,
                                     // sample_time, zero fill
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [95:0]  rsp_tdata,   // out_x, out_y, out_z
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [6:0]   csr_data     // key_count
);
   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_READ0, S_READ1, S_DIV, S_BLEND, S_OUT
   } state_type;

   localparam int SW = kflerp_pkg::SlotW;

   state_type state_ff;
   logic [kflerp_pkg::TimeW-1:0] time_mem [kflerp_pkg::MaxKeys];
   logic [95:0]                  val_mem  [kflerp_pkg::MaxKeys];
   logic [kflerp_pkg::CountW-1:0] count_ff;
   logic [SW:0]                  n_eff;
   logic [SW:0]                  idx_ff;
   logic [SW-1:0]                seg_ff;
   logic [kflerp_pkg::TimeW-1:0] rd_time_ff, samp_ff, t0_ff;
   logic [95:0]                  rd_val_ff, v0_ff, v1_ff;
   logic [95:0]                  out_ff;
   logic                         out_valid_ff, div_start, direct_ff;
   logic                         out_load;
   logic                         scan_valid_ff;
   logic [SW-1:0]                rd_addr;
   logic [kflerp_pkg::FracW-1:0] quot;
   logic                         div_done;
   kflerp_pkg::lane_ctl_type     ctl;
   logic [2:0]                   lane_done;
   logic [95:0]                  lane_res;

   assign n_eff = (count_ff == '0) ? 7'd1 :
                  (count_ff > 7'(kflerp_pkg::MaxKeys)) ? 7'(kflerp_pkg::MaxKeys) : count_ff;

   always_ff @(posedge clock) begin
      rd_time_ff <= time_mem[rd_addr];
      rd_val_ff  <= val_mem[rd_addr];
      if (req_tvalid && req_tready && req_tuser[0] == kflerp_pkg::CmdLoad) begin
         time_mem[req_tdata[5:0]] <= req_tdata[37:6];
         val_mem[req_tdata[5:0]]  <= req_tdata[133:38];
      end
   end

   always_comb begin
      rd_addr = idx_ff[SW-1:0];
      if (state_ff == S_READ0) rd_addr = seg_ff;
      if (state_ff == S_READ1) rd_addr = seg_ff + SW'(1);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign div_start  = (state_ff == S_READ1) && scan_valid_ff;
   assign out_load   = (state_ff == S_OUT) && (!out_valid_ff || rsp_tready);

   // Scan: read time[idx], registered; compare in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= 7'd1;
         out_valid_ff <= 1'b0;
         scan_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) count_ff <= csr_data;
         out_valid_ff <= out_load || (out_valid_ff && !rsp_tready);
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready && req_tuser[0] == kflerp_pkg::CmdSample) begin
                  samp_ff <= req_tdata[165:134];
                  if (n_eff == 7'd1) begin
                     seg_ff    <= '0;
                     direct_ff <= 1'b1;
                     state_ff  <= S_READ0;
                  end else begin
                     idx_ff        <= 7'd1;
                     seg_ff        <= SW'(n_eff - 7'd2);
                     direct_ff     <= 1'b0;
                     scan_valid_ff <= 1'b0;
                     state_ff      <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // rd_time_ff holds time[idx_ff-1] once scan_valid_ff is set.
               scan_valid_ff <= 1'b1;
               if (scan_valid_ff && samp_ff < rd_time_ff) begin
                  seg_ff   <= SW'(idx_ff - 7'd2);
                  state_ff <= S_READ0;
               end else if (scan_valid_ff && idx_ff == n_eff) begin
                  state_ff <= S_READ0;
               end else begin
                  idx_ff <= idx_ff + 7'd1;
               end
            end
            S_READ0: begin
               scan_valid_ff <= 1'b0;
               state_ff      <= S_READ1;
            end
            S_READ1: begin
               // The start key arrives first; the state then waits for the end key.
               if (!scan_valid_ff) begin
                  t0_ff <= rd_time_ff;
                  v0_ff <= rd_val_ff;
               end
               scan_valid_ff <= 1'b1;
               if (scan_valid_ff) state_ff <= S_DIV;
            end
            S_DIV: begin
               if (scan_valid_ff) begin
                  v1_ff <= rd_val_ff;
                  scan_valid_ff <= 1'b0;
                  if (direct_ff || rd_time_ff <= t0_ff) begin
                     direct_ff <= 1'b1;
                     state_ff  <= S_OUT;
                  end
               end else if (div_done) begin
                  state_ff <= S_BLEND;
               end
            end
            S_BLEND: begin
               if (lane_done[0]) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_load) begin
                  out_ff   <= direct_ff ? v0_ff : lane_res;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Divider launched when the end key arrives in S_DIV.
   logic div_go;
   assign div_go = (state_ff == S_DIV) && scan_valid_ff && !direct_ff && (rd_time_ff > t0_ff);

   kflerp_div u_div (
      .clock (clock), .reset (reset), .start (div_go && !div_start),
      .num   ((samp_ff > t0_ff) ? samp_ff - t0_ff : '0),
      .den   (rd_time_ff - t0_ff),
      .quot  (quot), .done (div_done)
   );

   assign ctl.start = (state_ff == S_DIV) && div_done;
   assign ctl.frac  = quot;

   for (genvar l = 0; l < kflerp_pkg::Lanes; l++) begin : g_lane
      kflerp_lane u_lane (
         .clock  (clock), .reset (reset), .ctl (ctl),
         .val_a  (v0_ff[32*l +: 32]), .val_b (v1_ff[32*l +: 32]),
         .result (lane_res[32*l +: 32]), .done (lane_done[l])
      );
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
endmodule
`default_nettype wire

// ===== design/kflerp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kflerp_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [95:0]  rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown(rsp_tdata))
      else $error("result holds unknown bits");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");
endmodule
bind keyframe_vec3_lerp_sampler kflerp_checker u_checker (
   .clock (clock), .reset (reset), .req_tvalid (req_tvalid), .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid), .rsp_tready (rsp_tready), .rsp_tdata (rsp_tdata)
);
`default_nettype wire

// ===== sim/tb_keyframe_vec3_lerp_sampler.sv =====
`timescale 1ns / 1ps
module tb_keyframe_vec3_lerp_sampler;
   localparam int CycleLimit = 3000000;
   localparam int DrainWait  = 160;

   // Holds the track as the block should see it and the blended values owed.
   class track_scoreboard;
      logic [kflerp_pkg::TimeW-1:0] key_times [kflerp_pkg::MaxKeys];
      logic [kflerp_pkg::ValW-1:0]  key_vals  [kflerp_pkg::MaxKeys][kflerp_pkg::Lanes];
      logic [kflerp_pkg::CountW-1:0] count_reg;
      logic [95:0]       owed [$];
      int                errors;

      function new();
         count_reg = 7'd1;
         errors = 0;
         for (int i = 0; i < kflerp_pkg::MaxKeys; i++) begin
            key_times[i] = '0;
            for (int c = 0; c < kflerp_pkg::Lanes; c++) key_vals[i][c] = '0;
         end
      endfunction

      function logic [kflerp_pkg::ValW-1:0] lerp_lane(logic [kflerp_pkg::ValW-1:0] a,
                                                      logic [kflerp_pkg::ValW-1:0] b,
                                                      longint unsigned f);
         longint sa, sb, p;
         sa = longint'($signed(a));
         sb = longint'($signed(b));
         p = (sb - sa) * longint'(f) + 32768;
         return kflerp_pkg::ValW'(sa + (p >>> 16));
      endfunction

      function logic [95:0] sample_track(logic [kflerp_pkg::TimeW-1:0] s);
         int n, seg;
         logic [kflerp_pkg::TimeW-1:0] t0, t1;
         longint unsigned q, f;
         logic [kflerp_pkg::ValW-1:0] r [kflerp_pkg::Lanes];
         n = count_reg;
         if (n == 0) n = 1;
         if (n > kflerp_pkg::MaxKeys) n = kflerp_pkg::MaxKeys;
         if (n == 1) return {key_vals[0][2], key_vals[0][1], key_vals[0][0]};
         seg = n - 2;
         for (int i = 0; i + 1 < n; i++) begin
            if (s < key_times[i+1]) begin
               seg = i;
               break;
            end
         end
         t0 = key_times[seg];
         t1 = key_times[seg+1];
         if (t1 <= t0) return {key_vals[seg][2], key_vals[seg][1], key_vals[seg][0]};
         if (s <= t0) f = 0;
         else begin
            q = (longint'(s - t0) << 16) / longint'(t1 - t0);
            f = (q > 65536) ? 65536 : q;
         end
         for (int c = 0; c < kflerp_pkg::Lanes; c++)
            r[c] = lerp_lane(key_vals[seg][c], key_vals[seg+1][c], f);
         return {r[2], r[1], r[0]};
      endfunction

      function void note_item(logic cmd, logic [167:0] d);
         logic [5:0] slot;
         slot = d[5:0];
         if (cmd == kflerp_pkg::CmdLoad) begin
            key_times[slot] = d[37:6];
            key_vals[slot][0] = d[69:38];
            key_vals[slot][1] = d[101:70];
            key_vals[slot][2] = d[133:102];
         end else begin
            owed.push_back(sample_track(d[165:134]));
         end
      endfunction

      function void check_result(logic [95:0] got);
         logic [95:0] want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = owed.pop_front();
         for (int c = 0; c < kflerp_pkg::Lanes; c++) begin
            if (got[c*32 +: 32] !== want[c*32 +: 32]) begin
               $display("%0t: lane %0d expected %h actual %h", $time, c,
                        want[c*32 +: 32], got[c*32 +: 32]);
               errors++;
            end
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   wire          req_tready;
   logic [0:0]   req_tuser = 0;
   logic [167:0] req_tdata = '0;
   wire          rsp_tvalid;
   logic         rsp_tready = 0;
   wire  [95:0]  rsp_tdata;
   logic         csr_valid = 0;
   wire          csr_ready;
   logic [6:0]   csr_data = 0;

   track_scoreboard sb = new();
   int  cycles = 0;
   bit  no_idle = 0;
   bit  hold_go = 0;
   bit  hold_done = 0;
   int  hold_left = 0;
   int  ready_gap = 0;
   logic [kflerp_pkg::TimeW-1:0] track_t [kflerp_pkg::MaxKeys];

   keyframe_vec3_lerp_sampler uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);

   // Receiver: random stalls, plus one long hold-off so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1;
         hold_left <= 3000;
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else if (ready_gap > 0) begin
         ready_gap <= ready_gap - 1;
         rsp_tready <= 0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
         ready_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                 : $urandom_range(0, 3);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   function automatic logic [167:0] pack_item(logic [5:0] slot, logic [31:0] t,
                                              logic [31:0] x, logic [31:0] y,
                                              logic [31:0] z, logic [31:0] s);
      return {2'b00, s, z, y, x, t, slot};
   endfunction

   task automatic send_item(logic cmd, logic [167:0] d);
      int gap;
      req_tvalid <= 1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sb.note_item(cmd, d);
      gap = 0;
      if (!no_idle && $urandom_range(0, 2) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                          : $urandom_range(1, 3);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_key(logic [5:0] slot, logic [31:0] t, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z);
      send_item(kflerp_pkg::CmdLoad, pack_item(slot, t, x, y, z, $urandom));
   endtask

   task automatic sample_at(logic [31:0] s);
      send_item(kflerp_pkg::CmdSample, pack_item(6'($urandom), $urandom, $urandom,
                                                 $urandom, $urandom, s));
   endtask

   // Only written once the block has drained; loads give no result, so wait more.
   task automatic write_count(logic [6:0] n);
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      csr_valid <= 1;
      csr_data  <= n;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      sb.count_reg = n;
      csr_valid <= 0;
   endtask

   task automatic build_track(int mode);
      logic [31:0] t;
      t = (mode == 2) ? 32'd0 : $urandom_range(0, 32'h0004_0000);
      for (int i = 0; i < kflerp_pkg::MaxKeys; i++) begin
         if (mode == 1) t = $urandom;
         else if (i > 0) begin
            case ($urandom_range(0, 7))
               0: t = t;
               1: t = t + $urandom_range(1, 4);
               default: t = t + $urandom_range(1, 32'h0008_0000);
            endcase
         end
         track_t[i] = t;
         load_key(6'(i), t, $urandom, $urandom, $urandom);
      end
   endtask

   function automatic logic [31:0] pick_time(int n);
      int k;
      n = (n == 0) ? 1 : (n > kflerp_pkg::MaxKeys ? kflerp_pkg::MaxKeys : n);
      k = $urandom_range(0, n - 1);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'd0;
         2: return 32'hFFFF_FFFF;
         3: return track_t[k];
         4: return track_t[k] - 1;
         5: return track_t[n-1] + $urandom_range(0, 32'h0010_0000);
         default: return track_t[k] + $urandom_range(0, 32'h0008_0000);
      endcase
   endfunction

   initial begin
      logic [6:0] n;
      logic [31:0] t;
      repeat (2) @(posedge clock);
      reset <= 0;

      // Every slot is loaded before any sample so nothing unwritten is read.
      no_idle = 1;
      for (int i = 0; i < kflerp_pkg::MaxKeys; i++) begin
         track_t[i] = i * 32'h0001_0000;
         load_key(6'(i), track_t[i], $urandom, $urandom, $urandom);
      end
      no_idle = 0;

      // Directed: value extremes, clamps, exact keys; keys 1 and 2 share a time.
      load_key(0, 32'h0000_1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      load_key(1, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      load_key(2, 32'h0002_0000, 32'h1234_5678, 32'h0000_0001, 32'h8000_0000);
      load_key(3, 32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFD, 32'h7FFF_FFFF);
      sample_at(32'h0000_0000);
      sample_at(32'h0000_1000);
      sample_at(32'h0001_0800);
      sample_at(32'h0001_FFFF);
      sample_at(32'h0002_0000);
      sample_at(32'h0003_0000);
      load_key(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      write_count(7'd2);
      sample_at(32'h0000_0000);
      sample_at(32'h0001_0800);
      sample_at(32'hFFFF_FFFF);
      write_count(7'd4);
      sample_at(32'h0002_0000);
      sample_at(32'h8000_0000);
      sample_at(32'hFFFF_FFFE);
      write_count(7'd0);
      sample_at(32'h0001_0000);
      write_count(7'd127);
      sample_at(32'hFFFF_FFFF);
      track_t[0] = 32'h1000; track_t[1] = 32'h20000;
      track_t[2] = 32'h20000; track_t[3] = 32'hFFFF_FFFF;

      for (int ph = 0; ph < 14; ph++) begin
         case (ph)
            0: n = 7'd1;
            1: n = 7'd64;
            2: n = 7'd2;
            3: n = 7'd127;
            4: n = 7'd0;
            default: n = 7'($urandom_range(0, 127));
         endcase
         write_count(n);
         no_idle = (ph % 5 == 2);
         if (ph % 4 == 0) build_track(ph % 3);
         if (ph == 6) hold_go = 1;
         for (int it = 0; it < 85; it++) begin
            if ($urandom_range(0, 9) == 0) begin
               t = $urandom;
               n = 7'($urandom);
               track_t[n[5:0]] = t;
               load_key(n[5:0], t, $urandom, $urandom, $urandom);
            end else begin
               sample_at(pick_time(sb.count_reg));
            end
         end
      end

      req_tvalid <= 0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (sb.errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
